// File: rtl/core/stop_and_wait_packet_receiver_assert.svh
// Assertion macros shared by the packet receiver RTL.
`ifndef STOP_AND_WAIT_PACKET_RECEIVER_ASSERT_SVH
`define STOP_AND_WAIT_PACKET_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked while reset is released.
`define SAW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while reset is released.
`define SAW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/saw_pkg.sv
// Types, constants and the CRC-32 byte step for the packet receiver.
`timescale 1ns / 1ps

package saw_pkg;

    localparam int PACKET_BYTES  = 1024;
    localparam int POS_W         = $clog2(PACKET_BYTES + 1);
    localparam int NUM_W         = 14;
    localparam int NUM_START     = 4;
    localparam int PAYLOAD_START = 8;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [7:0]  ASCII_ZERO = 8'h30;
    localparam logic [7:0]  ASCII_NINE = 8'h39;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_RESEND    = 2'd0,
        VERDICT_ACCEPT    = 2'd1,
        VERDICT_DUPLICATE = 2'd2,
        VERDICT_AHEAD     = 2'd3
    } t_verdict;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        t_verdict   verdict;
        logic       transfer_done;
    } t_result;

    // Up to two results are produced per input beat.
    typedef struct packed {
        logic [1:0] beats;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/core/saw_in_if.sv
// Byte input channel of the packet receiver.
`timescale 1ns / 1ps

interface saw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

// File: rtl/core/saw_out_if.sv
// Result output channel of the packet receiver.
`timescale 1ns / 1ps

interface saw_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] payload_byte;
    logic [1:0] verdict;
    logic       transfer_done;

    modport source (output valid, output kind, output payload_byte, output verdict,
                    output transfer_done, input ready);
    modport sink   (input valid, input kind, input payload_byte, input verdict,
                    input transfer_done, output ready);
endinterface

// File: rtl/core/saw_core.sv
// Input register, packet parsing, CRC check and verdict logic.
`timescale 1ns / 1ps
`include "stop_and_wait_packet_receiver_assert.svh"

module saw_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    saw_in_if.sink               i_rx,
    input  logic                 i_room,
    output saw_pkg::t_push       o_push
);

    logic                        r_in_valid;
    logic [7:0]                  r_in_byte;
    logic                        r_in_last;

    logic [31:0]                 r_file_size;
    logic [31:0]                 r_crc,      n_crc;
    logic [saw_pkg::POS_W-1:0]   r_pos,      n_pos;
    logic [31:0]                 r_rcrc,     n_rcrc;
    logic [saw_pkg::NUM_W-1:0]   r_num,      n_num;
    logic                        r_stop,     n_stop;
    logic [31:0]                 r_expected, n_expected;
    logic [31:0]                 r_committed, n_committed;
    logic                        r_done,     n_done;

    logic                        fire;
    logic                        is_digit;
    logic [saw_pkg::NUM_W+3:0]   num_mul;
    logic [saw_pkg::POS_W-1:0]   pay_cnt;
    logic [32:0]                 sum;
    logic                        crc_ok;
    saw_pkg::t_verdict           verdict;
    saw_pkg::t_result            pay_res;
    saw_pkg::t_result            ver_res;
    logic                        has_pay;

    assign fire        = r_in_valid && i_room;
    assign i_rx.ready  = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
            r_in_last <= i_rx.last_byte;
        end
    end

    assign is_digit = (r_in_byte >= saw_pkg::ASCII_ZERO) && (r_in_byte <= saw_pkg::ASCII_NINE);
    assign num_mul  = (saw_pkg::NUM_W + 4)'(r_num) * (saw_pkg::NUM_W + 4)'(10)
                    + (saw_pkg::NUM_W + 4)'(r_in_byte - saw_pkg::ASCII_ZERO);

    always_comb begin
        n_crc       = r_crc;
        n_pos       = r_pos;
        n_rcrc      = r_rcrc;
        n_num       = r_num;
        n_stop      = r_stop;
        n_expected  = r_expected;
        n_committed = r_committed;
        n_done      = r_done;
        has_pay     = 1'b0;
        verdict     = saw_pkg::VERDICT_RESEND;
        pay_cnt     = '0;
        sum         = '0;
        crc_ok      = 1'b0;

        if (r_pos < saw_pkg::POS_W'(saw_pkg::PACKET_BYTES)) begin
            if (r_pos < saw_pkg::POS_W'(saw_pkg::NUM_START)) begin
                n_rcrc = {r_rcrc[23:0], r_in_byte};
            end else if (r_pos < saw_pkg::POS_W'(saw_pkg::PAYLOAD_START)) begin
                if (!r_stop && is_digit) begin
                    n_num = num_mul[saw_pkg::NUM_W-1:0];
                end else begin
                    n_stop = 1'b1;
                end
            end else begin
                n_crc   = saw_pkg::crc32_byte(r_crc, r_in_byte);
                has_pay = 1'b1;
            end
            n_pos = r_pos + saw_pkg::POS_W'(1);
        end

        if (r_in_last) begin
            crc_ok = (n_pos >= saw_pkg::POS_W'(saw_pkg::PAYLOAD_START)) && (n_rcrc == ~n_crc);
            if (!crc_ok) begin
                verdict = saw_pkg::VERDICT_RESEND;
            end else if (r_expected < 32'(n_num)) begin
                verdict = saw_pkg::VERDICT_AHEAD;
            end else if (r_expected > 32'(n_num)) begin
                verdict = saw_pkg::VERDICT_DUPLICATE;
            end else begin
                verdict     = saw_pkg::VERDICT_ACCEPT;
                pay_cnt     = n_pos - saw_pkg::POS_W'(saw_pkg::PAYLOAD_START);
                sum         = {1'b0, r_committed} + 33'(pay_cnt);
                n_committed = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                n_expected  = r_expected + 32'd1;
                if (n_committed >= r_file_size) begin
                    n_done = 1'b1;
                end
            end
            // Start the next datagram from a clean slate.
            n_crc  = saw_pkg::CRC_INIT;
            n_pos  = '0;
            n_rcrc = '0;
            n_num  = '0;
            n_stop = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_size <= '0;
            r_crc       <= saw_pkg::CRC_INIT;
            r_pos       <= '0;
            r_rcrc      <= '0;
            r_num       <= '0;
            r_stop      <= 1'b0;
            r_expected  <= '0;
            r_committed <= '0;
            r_done      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_file_size <= i_cfg_wdata;
            end
            if (fire) begin
                r_crc       <= n_crc;
                r_pos       <= n_pos;
                r_rcrc      <= n_rcrc;
                r_num       <= n_num;
                r_stop      <= n_stop;
                r_expected  <= n_expected;
                r_committed <= n_committed;
                r_done      <= n_done;
            end
        end
    end

    always_comb begin
        pay_res.kind          = saw_pkg::KIND_PAYLOAD;
        pay_res.payload_byte  = r_in_byte;
        pay_res.verdict       = saw_pkg::VERDICT_RESEND;
        pay_res.transfer_done = r_done;

        ver_res.kind          = saw_pkg::KIND_VERDICT;
        ver_res.payload_byte  = 8'd0;
        ver_res.verdict       = verdict;
        ver_res.transfer_done = n_done;

        o_push.beats = '0;
        o_push.res0  = has_pay ? pay_res : ver_res;
        o_push.res1  = ver_res;
        if (fire) begin
            o_push.beats = 2'(has_pay) + 2'(r_in_last);
        end
    end

    `SAW_ASSERT_NEXT(a_done_sticky, i_clk, i_rst_n, r_done, r_done, "done flag cleared")
    `SAW_ASSERT_NOW(a_pos_bound, i_clk, i_rst_n, 1'b1,
        r_pos <= saw_pkg::POS_W'(saw_pkg::PACKET_BYTES), "byte position out of range")
    `SAW_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, fire && r_in_last,
        r_pos == '0 && r_crc == saw_pkg::CRC_INIT, "packet state not cleared after last beat")

endmodule

// File: rtl/core/saw_result_fifo.sv
// Small queue taking up to two results per cycle, issuing one beat per cycle while ready.
`timescale 1ns / 1ps
`include "stop_and_wait_packet_receiver_assert.svh"

module saw_result_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  saw_pkg::t_push  i_push,
    output logic            o_room,
    saw_out_if.source       o_res
);

    saw_pkg::t_result                r_mem [saw_pkg::OQ_DEPTH];
    logic [saw_pkg::OQ_PTR_W-1:0]    r_wr,    n_wr;
    logic [saw_pkg::OQ_PTR_W-1:0]    r_rd,    n_rd;
    logic [saw_pkg::OQ_PTR_W:0]      r_count, n_count;
    logic                            pop;
    saw_pkg::t_result                head;

    assign pop  = o_res.valid && o_res.ready;
    assign head = r_mem[r_rd];

    // Room for a full two-result push regardless of a pop this cycle.
    assign o_room = r_count <= (saw_pkg::OQ_PTR_W + 1)'(saw_pkg::OQ_DEPTH - 2);

    assign o_res.valid         = r_count != '0;
    assign o_res.kind          = head.kind;
    assign o_res.payload_byte  = head.payload_byte;
    assign o_res.verdict       = head.verdict;
    assign o_res.transfer_done = head.transfer_done;

    always_comb begin
        n_wr    = r_wr + saw_pkg::OQ_PTR_W'(i_push.beats);
        n_rd    = r_rd + saw_pkg::OQ_PTR_W'(pop);
        n_count = r_count + (saw_pkg::OQ_PTR_W + 1)'(i_push.beats)
                - (saw_pkg::OQ_PTR_W + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.beats != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.beats == 2'd2) begin
            r_mem[r_wr + saw_pkg::OQ_PTR_W'(1)] <= i_push.res1;
        end
    end

    `SAW_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push.beats != 2'd0,
        32'(r_count) + 32'(i_push.beats) <= 32'(saw_pkg::OQ_DEPTH), "result queue overflow")

endmodule

// File: rtl/core/stop_and_wait_packet_receiver.sv
// Top level of the stop-and-wait packet receiver.
// Usage:
//   i_rx carries one datagram byte per beat with last_byte marking its end.
//   Bytes 0..3 hold the big-endian CRC-32 of the payload, bytes 4..7 the ASCII
//   packet number, and bytes 8..1023 are payload; later bytes are ignored.
//   o_res carries results: every payload byte goes out at once as a tentative
//   beat, and the last byte of a datagram adds a verdict beat after it.
//   i_cfg_we/i_cfg_wdata load the transfer's file size; write it while idle.
// Timing:
//   An input beat is registered, evaluated from the input register and
//   written into a four-entry result queue that offers its results. One byte
//   is taken per cycle while the queue has room. A last byte that also
//   carries payload yields two result beats; the header bytes of the next
//   datagram yield none, so the queue catches up and input does not pause.
// Reset: clears the expected packet number, committed byte count, done flag,
//   file size and all queued results.
// Stalls: when o_res.ready is low the queue fills, and i_rx.ready falls once
//   fewer than two free entries remain; no result is dropped.
`timescale 1ns / 1ps

module stop_and_wait_packet_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    saw_in_if.sink      i_rx,
    saw_out_if.source   o_res
);

    saw_pkg::t_push push;
    logic           room;

    saw_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (i_rx),
        .i_room      (room),
        .o_push      (push)
    );

    saw_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_res   (o_res)
    );

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the stop-and-wait packet receiver.
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_rx_beat;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    saw_in_if  rx_if ();
    saw_out_if res_if ();

    stop_and_wait_packet_receiver uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_if),
        .o_res       (res_if)
    );

    // Receiver state as the testbench sees it.
    logic [31:0]               file_size_reg   = '0;
    logic [31:0]               pkt_crc         = saw_pkg::CRC_INIT;
    logic [saw_pkg::POS_W-1:0] pkt_pos         = '0;
    logic [31:0]               pkt_crc_field   = '0;
    logic [saw_pkg::NUM_W-1:0] pkt_number      = '0;
    logic                      pkt_number_end  = 1'b0;
    logic [31:0]               next_number     = '0;
    logic [31:0]               bytes_committed = '0;
    logic                      xfer_done       = 1'b0;

    saw_pkg::t_result awaited_results[$];
    t_rx_beat         rx_beats[$];
    t_rx_beat         next_beat;
    int               beats_queued = 0;
    int               gen_next     = 0;
    int               mismatches   = 0;
    int               rx_gap       = 0;
    int               res_gap      = 0;
    bit               steady       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Reflected CRC-32, one data bit per step, LSB first.
    function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ data[k];
            c  = c >> 1;
            if (fb) begin
                c = c ^ saw_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic receive_byte(input logic [7:0] b, input logic last);
        saw_pkg::t_result r;
        logic [31:0]      pkt_payload;
        if (pkt_pos < saw_pkg::PACKET_BYTES) begin
            if (pkt_pos < saw_pkg::NUM_START) begin
                pkt_crc_field = {pkt_crc_field[23:0], b};
            end else if (pkt_pos < saw_pkg::PAYLOAD_START) begin
                if (!pkt_number_end && b >= saw_pkg::ASCII_ZERO &&
                    b <= saw_pkg::ASCII_NINE) begin
                    pkt_number = saw_pkg::NUM_W'(pkt_number * 10 + (b - saw_pkg::ASCII_ZERO));
                end else begin
                    pkt_number_end = 1'b1;
                end
            end else begin
                pkt_crc           = crc32_update(pkt_crc, b);
                r.kind            = saw_pkg::KIND_PAYLOAD;
                r.payload_byte    = b;
                r.verdict         = saw_pkg::VERDICT_RESEND;
                r.transfer_done   = xfer_done;
                awaited_results.push_back(r);
            end
            pkt_pos = pkt_pos + 1'b1;
        end
        if (last) begin
            r.kind         = saw_pkg::KIND_VERDICT;
            r.payload_byte = '0;
            if (pkt_pos < saw_pkg::PAYLOAD_START || pkt_crc_field != ~pkt_crc) begin
                r.verdict = saw_pkg::VERDICT_RESEND;
            end else if (next_number < 32'(pkt_number)) begin
                r.verdict = saw_pkg::VERDICT_AHEAD;
            end else if (next_number > 32'(pkt_number)) begin
                r.verdict = saw_pkg::VERDICT_DUPLICATE;
            end else begin
                r.verdict   = saw_pkg::VERDICT_ACCEPT;
                pkt_payload = 32'(pkt_pos) - 32'(saw_pkg::PAYLOAD_START);
                if (bytes_committed > 32'hFFFF_FFFF - pkt_payload) begin
                    bytes_committed = 32'hFFFF_FFFF;
                end else begin
                    bytes_committed = bytes_committed + pkt_payload;
                end
                next_number = next_number + 32'd1;
                if (bytes_committed >= file_size_reg) begin
                    xfer_done = 1'b1;
                end
            end
            r.transfer_done = xfer_done;
            awaited_results.push_back(r);
            pkt_crc        = saw_pkg::CRC_INIT;
            pkt_pos        = '0;
            pkt_crc_field  = '0;
            pkt_number     = '0;
            pkt_number_end = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input saw_pkg::t_result want,
                                   input saw_pkg::t_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected kind %0d byte %02h verdict %0d done %0d", $time, what,
                     want.kind, want.payload_byte, want.verdict, want.transfer_done);
            $display("    got kind %0d byte %02h verdict %0d done %0d",
                     got.kind, got.payload_byte, got.verdict, got.transfer_done);
        end
    endtask

    task automatic check_result();
        saw_pkg::t_result got;
        saw_pkg::t_result want;
        got.kind          = res_if.kind;
        got.payload_byte  = res_if.payload_byte;
        got.verdict       = saw_pkg::t_verdict'(res_if.verdict);
        got.transfer_done = res_if.transfer_done;
        if (awaited_results.size() == 0) begin
            report_mismatch("unexpected result", '0, got);
        end else begin
            want = awaited_results.pop_front();
            if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
                got.verdict !== want.verdict || got.transfer_done !== want.transfer_done) begin
                report_mismatch("wrong result", want, got);
            end
        end
    endtask

    // Driver: one beat at a time from the pending queue, with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
            rx_gap      <= 0;
        end else if (!rx_if.valid || rx_if.ready) begin
            if (rx_gap != 0) begin
                rx_if.valid <= 1'b0;
                rx_gap      <= rx_gap - 1;
            end else if (!steady && $urandom_range(0, 5) == 0) begin
                rx_if.valid <= 1'b0;
                rx_gap      <= $urandom_range(0, 10);
            end else if (rx_beats.size() != 0) begin
                next_beat        = rx_beats.pop_front();
                rx_if.valid     <= 1'b1;
                rx_if.rx_byte   <= next_beat.data;
                rx_if.last_byte <= next_beat.last;
            end else begin
                rx_if.valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            res_gap      <= 0;
        end else if (res_gap != 0) begin
            res_if.ready <= 1'b0;
            res_gap      <= res_gap - 1;
        end else if (!steady && $urandom_range(0, 5) == 0) begin
            res_if.ready <= 1'b0;
            res_gap      <= $urandom_range(0, 10);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx_if.valid && rx_if.ready) begin
                receive_byte(rx_if.rx_byte, rx_if.last_byte);
            end
            if (res_if.valid && res_if.ready) begin
                check_result();
            end
        end
    end

    task automatic push_beat(input logic [7:0] data, input logic last);
        rx_beats.push_back('{data: data, last: last});
        beats_queued++;
    endtask

    // Number field: the decimal text, either zero padded or, when shorter, ended by a non-digit.
    function automatic logic [31:0] encode_number(input int value);
        string       txt;
        logic [31:0] field;
        logic [7:0]  stop_char;
        field = '0;
        txt = ($urandom_range(0, 1) == 0) ? $sformatf("%04d", value) : $sformatf("%0d", value);
        do begin
            stop_char = 8'($urandom_range(0, 255));
        end while (stop_char >= saw_pkg::ASCII_ZERO && stop_char <= saw_pkg::ASCII_NINE);
        for (int i = 0; i < 4; i++) begin
            if (i < txt.len()) begin
                field = {field[23:0], txt[i]};
            end else if (i == txt.len()) begin
                field = {field[23:0], stop_char};
            end else begin
                field = {field[23:0], 8'($urandom_range(0, 255))};
            end
        end
        return field;
    endfunction

    // The CRC covers only the payload that fits in a packet; the rest is dropped.
    task automatic queue_datagram(input logic [31:0] number_field, input logic [7:0] payload[$],
                                  input logic [31:0] crc_flip);
        logic [31:0] crc;
        crc = saw_pkg::CRC_INIT;
        for (int i = 0; i < payload.size() &&
             i < saw_pkg::PACKET_BYTES - saw_pkg::PAYLOAD_START; i++) begin
            crc = crc32_update(crc, payload[i]);
        end
        crc = ~crc ^ crc_flip;
        for (int i = 0; i < 4; i++) begin
            push_beat(crc[31 - 8 * i -: 8], 1'b0);
        end
        for (int i = 0; i < 4; i++) begin
            push_beat(number_field[31 - 8 * i -: 8], payload.size() == 0 && i == 3);
        end
        for (int i = 0; i < payload.size(); i++) begin
            push_beat(payload[i], i == payload.size() - 1);
        end
    endtask

    task automatic queue_noise(input int count);
        for (int i = 0; i < count; i++) begin
            push_beat(8'($urandom), i == count - 1 || $urandom_range(0, 15) == 0);
        end
    endtask

    task automatic queue_random_packet();
        logic [7:0]  payload[$];
        logic [31:0] flip;
        int          pick;
        int          len;
        int          number;
        pick   = $urandom_range(0, 99);
        len    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 40);
        flip   = '0;
        number = gen_next;
        for (int i = 0; i < len; i++) begin
            payload.push_back(8'($urandom));
        end
        if (pick < 62) begin
            gen_next++;
        end else if (pick < 72 && gen_next != 0) begin
            number = $urandom_range(0, gen_next - 1);
        end else if (pick < 80) begin
            number = $urandom_range(gen_next + 1, 9999);
        end else begin
            flip = 32'd1 << $urandom_range(0, 31);
        end
        if (pick < 88) begin
            queue_datagram(encode_number(number), payload, flip);
        end else begin
            queue_noise($urandom_range(1, 12));
        end
    endtask

    task automatic write_file_size(input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        file_size_reg  = value;
        @(posedge i_clk);
    endtask

    // Header beats give no result, so the wait goes on past the last awaited result.
    task automatic drain();
        while (rx_beats.size() != 0 || rx_if.valid || awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic queue_random_run(input int count);
        int target;
        target = beats_queued + count;
        while (beats_queued < target) begin
            queue_random_packet();
        end
    endtask

    initial begin
        logic [7:0] bytes_q[$];
        int         big_len;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_file_size(32'hFFFF_FFFF);

        // Packets that end before the payload starts.
        push_beat(8'h00, 1'b1);
        for (int i = 0; i < 7; i++) begin
            push_beat(8'hFF, i == 6);
        end
        // Empty payload: the CRC of nothing is zero.
        bytes_q.delete();
        queue_datagram({"0", ":", 8'h00, 8'hFF}, bytes_q, '0);
        bytes_q = '{8'h00, 8'hFF, 8'h55, 8'hAA};
        queue_datagram("0001", bytes_q, '0);
        bytes_q = '{8'h80};
        queue_datagram("1/99", bytes_q, '0);
        bytes_q = '{8'h01};
        queue_datagram("9999", bytes_q, '0);
        // A leading blank stops the number at zero.
        bytes_q.delete();
        queue_datagram(" 3  ", bytes_q, '0);
        bytes_q = '{8'h7F, 8'hFE};
        queue_datagram("0002", bytes_q, 32'h8000_0000);
        bytes_q = '{8'h3A};
        queue_datagram("2 ab", bytes_q, '0);
        bytes_q.delete();
        queue_datagram("12x9", bytes_q, '0);
        gen_next = 3;
        drain();

        queue_random_run(100);
        // One packet around the size limit, with any excess dropped.
        bytes_q.delete();
        big_len = $urandom_range(saw_pkg::PACKET_BYTES - saw_pkg::PAYLOAD_START - 2,
                                 saw_pkg::PACKET_BYTES + 30);
        for (int i = big_len; i > 0; i--) begin
            bytes_q.push_back(8'($urandom));
        end
        queue_datagram(encode_number(gen_next), bytes_q, '0);
        gen_next++;
        queue_random_run(150);
        drain();

        write_file_size(bytes_committed + 32'($urandom_range(20, 120)));
        queue_random_run(300);
        drain();

        steady = 1'b1;
        write_file_size('0);
        queue_random_run(280);
        drain();

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
